[rtl/h264_fu_a_packetizer_assert.svh]
// Assertion macros for the H.264 FU-A packetizer.
// Used by the top level; no other dependencies.
`ifndef H264_FU_A_PACKETIZER_ASSERT_SVH
`define H264_FU_A_PACKETIZER_ASSERT_SVH

`ifndef SYNTH
`define H264FU_ASSERT_IMPL(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("h264fu assertion failed");
`define H264FU_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("h264fu assertion failed");
`else
`define H264FU_ASSERT_IMPL(lbl, clk, rst, a, c)
`define H264FU_ASSERT_NEXT(lbl, clk, rst, a, c)
`endif

`endif

[rtl/h264fu_pkg.sv]
// Shared types and constants for the H.264 FU-A packetizer.
// No dependencies.
package h264fu_pkg;

  localparam int unsigned PAYLOAD_LIMIT = 1436;
  localparam int unsigned SIZE_W        = 11;
  localparam int unsigned LEN_W         = 16;
  localparam int unsigned RES_MAX       = 3;

  localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(3);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(PAYLOAD_LIMIT);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(PAYLOAD_LIMIT);

  localparam logic [7:0] NRI_MASK  = 8'hE0;
  localparam logic [7:0] FU_A_TYPE = 8'h1C;
  localparam logic [7:0] TYPE_MASK = 8'h1F;
  localparam logic [7:0] FU_START  = 8'h80;
  localparam logic [7:0] FU_END    = 8'h40;

  typedef struct packed {
    logic [7:0]       nal_byte;
    logic [LEN_W-1:0] nal_length;
    logic             picture_last_nal;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_end;
    logic       picture_end;
  } out_t;

  typedef out_t [RES_MAX-1:0] res_arr_t;

  typedef struct packed {
    logic [7:0]        held_header;
    logic [LEN_W-1:0]  bytes_left;
    logic [SIZE_W-1:0] packet_fill;
    logic              fragmenting;
    logic              first_fragment;
  } state_t;

endpackage

[rtl/h264fu_step.sv]
// Per-byte packetizer step: next state and up to three result words.
// Depends on h264fu_pkg.
module h264fu_step (
  input  h264fu_pkg::state_t              st,
  input  h264fu_pkg::in_t                 din,
  input  logic [h264fu_pkg::SIZE_W-1:0]   size,
  output h264fu_pkg::state_t              st_next,
  output h264fu_pkg::res_arr_t            res,
  output logic [1:0]                      n
);

  logic [h264fu_pkg::LEN_W-1:0]  len;
  logic [h264fu_pkg::LEN_W-1:0]  left_dec;
  logic [h264fu_pkg::LEN_W-1:0]  size_ext;
  logic [h264fu_pkg::LEN_W-1:0]  room_ext;
  logic [h264fu_pkg::SIZE_W-1:0] fill;
  logic [7:0]                    ind;
  logic [7:0]                    hdr;
  logic                          pe;
  logic                          hdr_ins;

  always_comb begin
    st_next  = st;
    res      = '0;
    n        = 2'd0;
    len      = (din.nal_length == '0) ? h264fu_pkg::LEN_W'(1) : din.nal_length;
    left_dec = st.bytes_left - h264fu_pkg::LEN_W'(1);
    size_ext = {{(h264fu_pkg::LEN_W - h264fu_pkg::SIZE_W){1'b0}}, size};
    room_ext = {{(h264fu_pkg::LEN_W - h264fu_pkg::SIZE_W){1'b0}},
                size - h264fu_pkg::SIZE_W'(2)};
    fill     = st.packet_fill;
    ind      = (st.held_header & h264fu_pkg::NRI_MASK) | h264fu_pkg::FU_A_TYPE;
    hdr      = st.held_header & h264fu_pkg::TYPE_MASK;
    pe       = 1'b0;
    hdr_ins  = 1'b0;

    if (st.bytes_left == '0) begin
      // NAL start
      st_next.bytes_left = len - h264fu_pkg::LEN_W'(1);
      if (len <= size_ext) begin
        st_next.fragmenting = 1'b0;
        pe     = (len == h264fu_pkg::LEN_W'(1));
        res[0] = '{out_byte: din.nal_byte, packet_end: pe,
                   picture_end: pe & din.picture_last_nal};
        n      = 2'd1;
      end else begin
        st_next.fragmenting    = 1'b1;
        st_next.held_header    = din.nal_byte;
        st_next.first_fragment = 1'b1;
        st_next.packet_fill    = '0;
      end
    end else if (!st.fragmenting) begin
      st_next.bytes_left = left_dec;
      pe     = (left_dec == '0);
      res[0] = '{out_byte: din.nal_byte, packet_end: pe,
                 picture_end: pe & din.picture_last_nal};
      n      = 2'd1;
    end else begin
      if (st.packet_fill == '0) begin
        hdr_ins = 1'b1;
        if (st.first_fragment) begin
          hdr = hdr | h264fu_pkg::FU_START;
        end else if (st.bytes_left <= room_ext) begin
          hdr = hdr | h264fu_pkg::FU_END;
        end
        res[0] = '{out_byte: ind, packet_end: 1'b0, picture_end: 1'b0};
        res[1] = '{out_byte: hdr, packet_end: 1'b0, picture_end: 1'b0};
        fill   = h264fu_pkg::SIZE_W'(2);
      end
      fill = fill + h264fu_pkg::SIZE_W'(1);
      pe   = (left_dec == '0) || (fill >= size);
      if (hdr_ins) begin
        res[2] = '{out_byte: din.nal_byte, packet_end: pe,
                   picture_end: (left_dec == '0) & din.picture_last_nal};
        n      = 2'd3;
      end else begin
        res[0] = '{out_byte: din.nal_byte, packet_end: pe,
                   picture_end: (left_dec == '0) & din.picture_last_nal};
        n      = 2'd1;
      end
      st_next.bytes_left  = left_dec;
      st_next.packet_fill = fill;
      if (pe) begin
        st_next.packet_fill    = '0;
        st_next.first_fragment = 1'b0;
      end
      if (left_dec == '0) begin
        st_next.fragmenting    = 1'b0;
        st_next.first_fragment = 1'b1;
        st_next.packet_fill    = '0;
      end
    end
  end

endmodule

[rtl/h264_fu_a_packetizer.sv]
// H.264 RTP FU-A packetizer, one NAL byte in, one payload word out per cycle while
// out_ready is high. The first result word is registered and valid in the cycle
// after input accept. Input takes one byte per cycle while out_ready is high;
// the first data byte of a fragment yields three words (FU indicator, FU header,
// data) and holds off input while the 3-entry output buffer drains. Synchronous
// active-high reset resets state; max_payload resets to 1436.
// Depends on h264fu_pkg, h264fu_step and h264_fu_a_packetizer_assert.svh.
`include "h264_fu_a_packetizer_assert.svh"

module h264_fu_a_packetizer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [h264fu_pkg::SIZE_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  h264fu_pkg::in_t               in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output h264fu_pkg::out_t              out_data
);

  logic [h264fu_pkg::SIZE_W-1:0] max_payload;
  logic [h264fu_pkg::SIZE_W-1:0] size;
  h264fu_pkg::state_t            st;
  h264fu_pkg::state_t            st_next;
  h264fu_pkg::res_arr_t          res;
  h264fu_pkg::res_arr_t          obuf;
  logic [1:0]                    n;
  logic [1:0]                    cnt;
  logic                          push;
  logic                          pop;

  always_comb begin
    if (max_payload < h264fu_pkg::SIZE_MIN) begin
      size = h264fu_pkg::SIZE_MIN;
    end else if (max_payload > h264fu_pkg::SIZE_MAX) begin
      size = h264fu_pkg::SIZE_MAX;
    end else begin
      size = max_payload;
    end
  end

  h264fu_step u_step (
    .st      (st),
    .din     (in_data),
    .size    (size),
    .st_next (st_next),
    .res     (res),
    .n       (n)
  );

  assign out_valid = (cnt != 2'd0);
  assign out_data  = obuf[0];
  assign pop       = out_valid && out_ready;
  // take a byte when the buffer is empty or empties this cycle
  assign in_ready  = (cnt == 2'd0) || ((cnt == 2'd1) && out_ready);
  assign push      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= h264fu_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      max_payload <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.held_header    <= '0;
      st.bytes_left     <= '0;
      st.packet_fill    <= '0;
      st.fragmenting    <= 1'b0;
      st.first_fragment <= 1'b1;
    end else if (push) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (push) begin
      cnt <= n;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      obuf <= res;
    end else if (pop) begin
      obuf[0] <= obuf[1];
      obuf[1] <= obuf[2];
    end
  end

  `H264FU_ASSERT_IMPL(a_frag_has_data, clk, rst, st.fragmenting, st.bytes_left != '0)
  `H264FU_ASSERT_IMPL(a_pic_end_on_pkt_end, clk, rst,
                      out_valid && out_data.picture_end, out_data.packet_end)
  `H264FU_ASSERT_NEXT(a_fu_indicator_first, clk, rst, push && (n == 2'd3),
                      (out_data.out_byte[4:0] == h264fu_pkg::FU_A_TYPE[4:0]) &&
                      !out_data.packet_end)
  // a size change can leave the open fill above the new size, never above the limit
  `H264FU_ASSERT_IMPL(a_fill_below_limit, clk, rst, st.fragmenting,
                      st.packet_fill < h264fu_pkg::SIZE_MAX)

endmodule
